// File: hw/rtl/cia_pkg.sv
// ----------------------------------------------------------------------------
// cia_pkg - checked integer alu shared definitions
// word types, operation and status codes, pipeline latencies
// ----------------------------------------------------------------------------
package cia_pkg;

  // operation codes
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_DIV = 3'd2;
  localparam logic [2:0] OP_MUL = 3'd3;
  localparam logic [2:0] OP_MOD = 3'd4;

  // width selector codes
  localparam logic [1:0] WSEL_8  = 2'd0;
  localparam logic [1:0] WSEL_16 = 2'd1;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int OPND_BITS      = 32;

  // divider: one register stage for the operands, one per quotient bit
  localparam int DIV_LAT  = OPND_BITS + 1;
  // input stage + divider + select stage + check stage
  localparam int PIPE_LAT = DIV_LAT + 3;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [1:0]         width_sel;
    logic signed [31:0] lhs;
    logic signed [31:0] rhs;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic [1:0]         status;
  } out_word_t;

endpackage

// File: hw/rtl/cia_div.sv
// ----------------------------------------------------------------------------
// cia_div - pipelined unsigned divider
// restoring division, one quotient bit per register stage
// ----------------------------------------------------------------------------
module cia_div #(
  parameter int N = 32
) (
  input  logic         clk,
  input  logic [N-1:0] dividend,
  input  logic [N-1:0] divisor,
  output logic [N-1:0] quot,
  output logic [N-1:0] rem
);

  logic [N-1:0] a_r   [N+1];
  logic [N-1:0] d_r   [N+1];
  logic [N-1:0] q_r   [N+1];
  logic [N-1:0] rem_r [N+1];

  // operand capture
  always_ff @(posedge clk) begin
    a_r[0]   <= dividend;
    d_r[0]   <= divisor;
    q_r[0]   <= '0;
    rem_r[0] <= '0;
  end

  // one trial subtract per stage
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [N:0] trial;
    logic [N:0] diff;
    logic       ge;

    assign trial = {rem_r[k], a_r[k][N-1]};
    assign diff  = trial - {1'b0, d_r[k]};
    assign ge    = (trial >= {1'b0, d_r[k]});

    always_ff @(posedge clk) begin
      rem_r[k+1] <= ge ? diff[N-1:0] : trial[N-1:0];
      q_r[k+1]   <= {q_r[k][N-2:0], ge};
      a_r[k+1]   <= {a_r[k][N-2:0], 1'b0};
      d_r[k+1]   <= d_r[k];
    end
  end

  assign quot = q_r[N];
  assign rem  = rem_r[N];

endmodule

// File: hw/rtl/checked_integer_alu.sv
// ----------------------------------------------------------------------------
// checked_integer_alu - signed add/sub/mul/div/mod with overflow checking
// fully pipelined, one operation accepted per clock
// ----------------------------------------------------------------------------
// A word is taken on every clock edge with start high; busy is always low.
// From start to the out_valid strobe every operation passes the input stage,
// the 33-stage divider pipeline, the select stage and the check stage, so results
// leave in order. The result is shown for exactly one cycle and the receiver
// cannot hold it off. Overflow and divide by zero give a zero result.
module checked_integer_alu
  import cia_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam int WIDE_BITS = (DATA_WIDTH > 32) ? 32 : ((DATA_WIDTH < 8) ? 8 : DATA_WIDTH);

  typedef struct packed {
    logic [2:0]         cmd;
    logic [5:0]         w;
    logic signed [63:0] arith;
    logic               neg_q;
    logic               neg_r;
    logic               zero;
  } side_t;

  assign busy = 1'b0;

  // width decode and sign extension
  logic [5:0]         w_in;
  logic signed [31:0] x_in, y_in;
  logic [5:0]         sh_in;

  always_comb begin
    case (in_word.width_sel)
      WSEL_8:  w_in = 6'd8;
      WSEL_16: w_in = 6'd16;
      default: w_in = 6'(WIDE_BITS);
    endcase
    sh_in = 6'd32 - w_in;
    x_in  = (in_word.lhs <<< sh_in) >>> sh_in;
    y_in  = (in_word.rhs <<< sh_in) >>> sh_in;
  end

  // stage 1: operand registers
  logic               v1_r;
  logic [2:0]         cmd1_r;
  logic [5:0]         w1_r;
  logic signed [31:0] x1_r, y1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    cmd1_r <= in_word.cmd;
    w1_r   <= w_in;
    x1_r   <= x_in;
    y1_r   <= y_in;
  end

  // stage 2: add, sub, mul and divider operand magnitudes
  side_t       side_nxt;
  logic [31:0] ax, ay;

  always_comb begin
    side_nxt.cmd   = cmd1_r;
    side_nxt.w     = w1_r;
    side_nxt.neg_q = x1_r[31] ^ y1_r[31];
    side_nxt.neg_r = x1_r[31];
    side_nxt.zero  = (y1_r == '0);
    case (cmd1_r)
      OP_ADD:  side_nxt.arith = 64'(x1_r) + 64'(y1_r);
      OP_SUB:  side_nxt.arith = 64'(x1_r) - 64'(y1_r);
      OP_MUL:  side_nxt.arith = 64'(x1_r) * 64'(y1_r);
      default: side_nxt.arith = '0;
    endcase
    ax = x1_r[31] ? 32'(-x1_r) : x1_r;
    ay = y1_r[31] ? 32'(-y1_r) : y1_r;
  end

  logic [31:0] quot, rem;

  cia_div #(.N(OPND_BITS)) u_div (
    .clk      (clk),
    .dividend (ax),
    .divisor  (ay),
    .quot     (quot),
    .rem      (rem)
  );

  // sideband delay line matched to the divider
  side_t side_r [DIV_LAT];
  logic  vd_r   [DIV_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) vd_r[i] <= 1'b0;
    end else begin
      vd_r[0] <= v1_r;
      for (int i = 1; i < DIV_LAT; i++) vd_r[i] <= vd_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= side_nxt;
    for (int i = 1; i < DIV_LAT; i++) side_r[i] <= side_r[i-1];
  end

  // select stage: add/sub/mul result, signed quotient or signed remainder
  side_t              sd;
  logic signed [63:0] r_nxt;
  logic               div0_nxt;

  always_comb begin
    sd       = side_r[DIV_LAT-1];
    div0_nxt = 1'b0;
    case (sd.cmd) inside
      OP_ADD, OP_SUB, OP_MUL: r_nxt = sd.arith;
      OP_DIV: begin
        r_nxt    = sd.neg_q ? -$signed({32'b0, quot}) : $signed({32'b0, quot});
        div0_nxt = sd.zero;
      end
      OP_MOD: begin
        r_nxt    = sd.neg_r ? -$signed({32'b0, rem}) : $signed({32'b0, rem});
        div0_nxt = sd.zero;
      end
      default: r_nxt = '0;
    endcase
  end

  logic               vf_r;
  logic signed [63:0] rf_r;
  logic               div0f_r;
  logic [5:0]         wf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else begin
      vf_r <= vd_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    rf_r    <= r_nxt;
    div0f_r <= div0_nxt;
    wf_r    <= sd.w;
  end

  // check stage: divide-by-zero flag first, then range test against the selected width
  logic signed [63:0] lim;
  logic               fits;
  out_word_t          out_nxt;

  always_comb begin
    lim  = 64'sd1 <<< (wf_r - 6'd1);
    fits = (rf_r >= -lim) && (rf_r <= lim - 64'sd1);
    if (div0f_r) begin
      out_nxt.status = ST_DIV0;
      out_nxt.result = '0;
    end else if (!fits) begin
      out_nxt.status = ST_OVF;
      out_nxt.result = '0;
    end else begin
      out_nxt.status = ST_OK;
      out_nxt.result = rf_r[31:0];
    end
  end

  logic      vo_r;
  out_word_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else begin
      vo_r <= vf_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = vo_r;
  assign out_word  = out_r;

endmodule

// File: hw/rtl/cia_chk.sv
// ----------------------------------------------------------------------------
// cia_chk - port checker for checked_integer_alu
// fixed latency, flagged words carry zero, zero divisor only on div or mod
// ----------------------------------------------------------------------------
module cia_chk
  import cia_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_word_t  in_word,
  input logic      out_valid,
  input out_word_t out_word
);

  // every result word traces back to a start a fixed time earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result word without matching start");

  // a flagged word carries a zero result
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status != ST_OK) |-> (out_word.result == '0))
    else $error("flagged word with nonzero result");

  // status code stays in its range
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.status == ST_OK || out_word.status == ST_OVF ||
                   out_word.status == ST_DIV0))
    else $error("bad status code");

  // zero divisor flag only for divide or modulo
  a_div0: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status == ST_DIV0) |->
      ($past(in_word.cmd, PIPE_LAT) == OP_DIV || $past(in_word.cmd, PIPE_LAT) == OP_MOD))
    else $error("zero divisor flag on a non-divide word");

endmodule

bind checked_integer_alu cia_chk u_cia_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_word  (out_word)
);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench - checked integer alu
// drives directed and random words with random gaps, predicts each result
// and compares it in order against what the alu strobes out
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import cia_pkg::*;

  // expected results in issue order
  class alu_scoreboard;
    out_word_t pending[$];
    int unsigned n_fail;
    int unsigned n_checked;

    // work out the checked result of one word
    function out_word_t predict(in_word_t w);
      out_word_t o;
      int unsigned nb;
      longint x, y, r, lo, hi;
      logic [1:0] st;
      nb = (w.width_sel == WSEL_8) ? 8 : (w.width_sel == WSEL_16) ? 16 : 32;
      x = longint'(w.lhs) & ((64'd1 << nb) - 1);
      y = longint'(w.rhs) & ((64'd1 << nb) - 1);
      if (x[nb-1]) x = x - (64'sd1 <<< nb);
      if (y[nb-1]) y = y - (64'sd1 <<< nb);
      lo = -(64'sd1 <<< (nb - 1));
      hi = (64'sd1 <<< (nb - 1)) - 1;
      r = 0;
      st = ST_OK;
      case (w.cmd)
        OP_ADD: r = x + y;
        OP_SUB: r = x - y;
        OP_MUL: r = x * y;
        OP_DIV: if (y == 0) st = ST_DIV0; else r = x / y;
        OP_MOD: if (y == 0) st = ST_DIV0; else r = x % y;
        default: r = 0;
      endcase
      if (st == ST_OK && (r < lo || r > hi)) st = ST_OVF;
      if (st != ST_OK) r = 0;
      o.result = r[31:0];
      o.status = st;
      return o;
    endfunction

    function void note_word(in_word_t w);
      pending.push_back(predict(w));
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h/%0d", $time, got.result, got.status);
        n_fail++;
        return;
      end
      exp_w = pending.pop_front();
      n_checked++;
      if (got.result !== exp_w.result) begin
        $display("%0t: result mismatch exp %h got %h", $time, exp_w.result, got.result);
        n_fail++;
      end
      if (got.status !== exp_w.status) begin
        $display("%0t: status mismatch exp %0d got %0d", $time, exp_w.status, got.status);
        n_fail++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_valid;
  out_word_t out_word;
  longint    cycles;
  int unsigned n_sent;
  alu_scoreboard sb;

  checked_integer_alu u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result monitor and cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) sb.check_result(out_word);
    if (cycles > 200000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // issue one word, holding start until accepted, after a random gap if gaps is set
  task automatic send_word(in_word_t w, bit gaps);
    int unsigned gap;
    gap = gaps ? $urandom_range(0, 18) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(w);
    n_sent++;
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000 | ($urandom & 32'hffff_ff80);
      1: return 32'hffff_ffff;
      2: return 32'h0000_0000;
      3: return {$urandom_range(0, 1) ? 24'hffffff : 24'h0, 8'($urandom)};
      4: return {$urandom_range(0, 1) ? 16'hffff : 16'h0, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  initial begin
    in_word_t w;
    logic [31:0] ext[6];
    bit gaps;
    sb = new();
    cycles = 0;
    n_sent = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes at each width, every operation, zero divisor,
    // most negative by minus one, unused codes
    ext = '{32'h0000_0080, 32'h0000_8000, 32'h8000_0000,
            32'hffff_ffff, 32'h7fff_ffff, 32'h0};
    for (int c = 0; c < 8; c++) begin
      w.cmd = c[2:0];
      w.width_sel = c[1:0];
      w.lhs = ext[c % 3];
      w.rhs = 32'hffff_ffff;
      send_word(w, 1'b0);
    end
    for (int s = 0; s < 4; s++) begin
      w.cmd = OP_DIV; w.width_sel = s[1:0]; w.lhs = ext[2]; w.rhs = 32'h0;
      send_word(w, 1'b0);
      w.cmd = OP_MOD; w.rhs = 32'hffff_ff00;
      send_word(w, 1'b1);
      w.cmd = OP_MUL; w.lhs = 32'h7fff_ffff; w.rhs = 32'h7fff_ffff;
      send_word(w, 1'b0);
    end

    // random part: bursts with and without gaps
    for (int i = 0; i < 750; i++) begin
      if (i % 60 == 0) gaps = $urandom_range(0, 2) != 0;
      w.cmd = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
      w.width_sel = 2'($urandom);
      w.lhs = pick_operand();
      w.rhs = pick_operand();
      send_word(w, gaps);
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
    $display("tb: %0d words issued, %0d results checked across all operations and widths",
             n_sent, sb.n_checked);
    if (sb.n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
